// ----- src/lgrs_pkg.sv -----
// lgrs_pkg: shared types, codes and constants of the Laplace grid relaxation solver.
// No dependencies; imported by lgrs_cell and the top level.
package lgrs_pkg;

   localparam int GRID_N_DEF = 32;

   localparam int VAL_W    = 19;   // signed Q3.16 cell value
   localparam int CHG_W    = 18;   // reported change
   localparam int SWEEP_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int COORD_W  = 7;
   localparam int ACT_W    = 2;
   localparam int METHOD_W = 2;
   localparam int OMEGA_W  = 16;

   localparam logic signed [VAL_W-1:0] VAL_ONE  = 19'sd65536;
   localparam logic signed [VAL_W-1:0] VAL_LO   = -19'sd131072;
   localparam logic signed [VAL_W-1:0] VAL_HI   = 19'sd196607;
   localparam logic [VAL_W-1:0]        CHG_SAT  = 19'd196607;
   localparam logic [OMEGA_W-1:0]      OMEGA_MAX = 16'd32768;

   // methods
   localparam logic [METHOD_W-1:0] METH_JACOBI = 2'd0;
   localparam logic [METHOD_W-1:0] METH_GS     = 2'd1;
   localparam logic [METHOD_W-1:0] METH_SOR    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXSW  = 2'd3;

   // register reset values
   localparam logic [METHOD_W-1:0] METHOD_RST = METH_JACOBI;
   localparam logic [CSR_W-1:0]    RELAX_RST  = 16'd16384;
   localparam logic [CSR_W-1:0]    TOL_RST    = 16'd66;
   localparam logic [CSR_W-1:0]    MAXSW_RST  = 16'd1000;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_SOLVE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } lgrs_action_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRAP,
      ST_RECT,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_SOLVE,
      ST_CELL,
      ST_BOUND,
      ST_CHECK,
      ST_RESP
   } lgrs_state_type;

   // control of the cell update unit
   typedef struct packed {
      logic load_center;
      logic add_nbr;
      logic calc_avg;
      logic calc_diff;
      logic calc_prod;
      logic sor;
   } lgrs_cu_ctrl_type;

endpackage

// ----- src/lgrs_ram.sv -----
// lgrs_ram: generic one-write, one-read synchronous RAM with registered read.
// No dependencies.
module lgrs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lgrs_cell.sv -----
// lgrs_cell: per-cell update datapath (neighbor sum, average, SOR step, saturation).
// Depends on lgrs_pkg.
module lgrs_cell
   import lgrs_pkg::*;
(
   input  logic                     clock,
   input  lgrs_cu_ctrl_type         ctrl,
   input  logic signed [VAL_W-1:0]  rd_value,
   input  logic                     obs,
   input  logic [OMEGA_W-1:0]       omega,
   output logic signed [VAL_W-1:0]  new_value,
   output logic [VAL_W-1:0]         change
);

   localparam int SUM_W  = VAL_W + 2;
   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = DIFF_W + OMEGA_W + 1;
   localparam int STEP_W = PROD_W - 14;
   localparam int RAW_W  = STEP_W + 1;

   logic signed [VAL_W-1:0]  old_ff;
   logic                     obs_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [VAL_W-1:0]  avg_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [STEP_W-1:0] step;
   logic signed [RAW_W-1:0]  raw;
   logic signed [VAL_W-1:0]  sat;
   logic signed [DIFF_W-1:0] delta;

   always_ff @(posedge clock) begin
      if (ctrl.load_center) begin
         old_ff <= rd_value;
         obs_ff <= obs;
         sum_ff <= '0;
      end
      if (ctrl.add_nbr) begin
         sum_ff <= sum_ff + SUM_W'(rd_value);
      end
      if (ctrl.calc_avg) begin
         // floor((sum + 2) / 4)
         avg_ff <= VAL_W'((sum_ff + SUM_W'(2)) >>> 2);
      end
      if (ctrl.calc_diff) begin
         diff_ff <= DIFF_W'(avg_ff) - DIFF_W'(old_ff);
      end
      if (ctrl.calc_prod) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'($signed({1'b0, omega}));
      end
   end

   always_comb begin
      step = STEP_W'((prod_ff + PROD_W'(8192)) >>> 14);
      if (ctrl.sor) begin
         raw = RAW_W'(old_ff) + RAW_W'(step);
      end else begin
         raw = RAW_W'(avg_ff);
      end
      if (raw < RAW_W'(VAL_LO)) begin
         sat = VAL_LO;
      end else if (raw > RAW_W'(VAL_HI)) begin
         sat = VAL_HI;
      end else begin
         sat = VAL_W'(raw);
      end
      delta = DIFF_W'(sat) - DIFF_W'(old_ff);
   end

   assign new_value = obs_ff ? '0 : sat;
   assign change    = obs_ff ? '0 :
                      (delta[DIFF_W-1] ? VAL_W'(-delta) : VAL_W'(delta));

endmodule

// ----- src/laplace_grid_relaxation_solver.sv -----
// laplace_grid_relaxation_solver: top level; sequencer around the field and obstacle memories.
// Depends on lgrs_pkg, lgrs_ram and lgrs_cell.
//
// Laplace solver on a cylindrical grid of GRID_N columns by GRID_N+1 rows, values signed
// Q3.16. The state lives in two RAMs: the field (two banks, swapped by a bank bit for
// Jacobi) and a one-bit obstacle map. After reset an init pass writes the boundary rows
// and clears the obstacle map; no item is taken during it, config writes are. Each item
// yields exactly one response transfer. Read and add first reduce the column modulo the
// grid width; add then marks the rectangle cell by cell. A solve sweep is bounded by
// the single field read port: each interior cell takes five reads, then average,
// difference, omega multiply and write back, and the next cell starts only after the
// write, so Gauss-Seidel and SOR see fresh neighbors with no forwarding. The boundary
// rows are rewritten after the interior pass. Responses sit in an output register, so
// a new request can be taken while the previous response transfer is still pending.
module laplace_grid_relaxation_solver
   import lgrs_pkg::*;
#(
   parameter int GRID_N = GRID_N_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACT_W-1:0]           req_action,
   input  logic signed [COORD_W-1:0]  req_col_first,
   input  logic signed [COORD_W-1:0]  req_col_last,
   input  logic signed [COORD_W-1:0]  req_row_first,
   input  logic signed [COORD_W-1:0]  req_row_last,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VAL_W-1:0]    rsp_cell_value,
   output logic [SWEEP_W-1:0]         rsp_sweeps_done,
   output logic [CHG_W-1:0]           rsp_final_change,
   output logic                       rsp_converged,
   // config
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   localparam int ROWS     = GRID_N + 1;
   localparam int CELLS    = GRID_N * ROWS;
   localparam int CELL_AW  = $clog2(CELLS);
   localparam int FDEPTH   = 2 * CELLS;
   localparam int FA_W     = $clog2(FDEPTH);
   localparam int IDX_W    = $clog2(GRID_N);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int TOP_BASE = GRID_N * GRID_N;
   localparam int CMP_W    = (ROW_W > COORD_W ? ROW_W : COORD_W) + 2;
   localparam int WR_W     = (IDX_W > COORD_W ? IDX_W : COORD_W) + 2;
   localparam int PH_W     = 4;

   localparam logic [IDX_W-1:0]   IDX_MAX  = IDX_W'(GRID_N - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST_INT = ROW_W'(ROWS - 2);
   localparam logic [CELL_AW-1:0] ROW_STEP = CELL_AW'(GRID_N);
   localparam logic [CELL_AW-1:0] CLR_LAST = CELL_AW'(CELLS - 1);

   // cell phases: reads issued in 0..4, data back in 1..5
   localparam logic [PH_W-1:0] PH_CENTER = 4'd0;
   localparam logic [PH_W-1:0] PH_LEFT   = 4'd1;
   localparam logic [PH_W-1:0] PH_RIGHT  = 4'd2;
   localparam logic [PH_W-1:0] PH_UP     = 4'd3;
   localparam logic [PH_W-1:0] PH_DOWN   = 4'd4;
   localparam logic [PH_W-1:0] PH_NLAST  = 4'd5;
   localparam logic [PH_W-1:0] PH_AVG    = 4'd6;
   localparam logic [PH_W-1:0] PH_DIFF   = 4'd7;
   localparam logic [PH_W-1:0] PH_PROD   = 4'd8;
   localparam logic [PH_W-1:0] PH_WRITE  = 4'd9;

   // ---------------- registers ----------------
   lgrs_state_type            state_ff, state_in;

   logic [METHOD_W-1:0]       method_ff;
   logic [CSR_W-1:0]          relax_ff, tol_ff, maxsw_ff;

   lgrs_action_type           act_ff, act_in;
   logic signed [COORD_W-1:0] c0_ff, c0_in, c1_ff, c1_in, ccnt_ff, ccnt_in;
   logic [ROW_W-1:0]          rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic                      empty_ff, empty_in;
   logic signed [WR_W-1:0]    wc_ff, wc_in;
   logic [IDX_W-1:0]          wc0_ff, wc0_in;
   logic [IDX_W-1:0]          i_ff, i_in;
   logic [ROW_W-1:0]          j_ff, j_in;
   logic [CELL_AW-1:0]        rowbase_ff, rowbase_in;
   logic [CELL_AW-1:0]        clr_ff, clr_in;
   logic [PH_W-1:0]           phase_ff, phase_in;
   logic                      top_ff, top_in;
   logic                      bank_ff, bank_in;
   logic [VAL_W-1:0]          big_ff, big_in;
   logic [SWEEP_W-1:0]        sweeps_ff, sweeps_in;
   logic                      conv_ff, conv_in;
   logic signed [VAL_W-1:0]   cell_ff, cell_in;

   logic                      rsp_valid_ff;
   logic signed [VAL_W-1:0]   rsp_cell_ff;
   logic [SWEEP_W-1:0]        rsp_sweeps_ff;
   logic [CHG_W-1:0]          rsp_change_ff;
   logic                      rsp_conv_ff;

   // ---------------- combinational ----------------
   logic                      jac;
   logic [OMEGA_W-1:0]        omega;
   logic                      req_fire, rsp_load;
   logic [CELL_AW-1:0]        p_addr, bnd_addr;
   logic [IDX_W-1:0]          left_idx, right_idx;
   logic [CELL_AW-1:0]        fld_rcell, fld_wcell, obs_raddr, obs_waddr;
   logic                      fld_wbank, fld_we, obs_we, obs_wdata;
   logic signed [VAL_W-1:0]   fld_wdata, fld_rdata, cu_new;
   logic [FA_W-1:0]           fld_raddr, fld_waddr;
   logic                      obs_rdata;
   logic [VAL_W-1:0]          cu_change;
   lgrs_cu_ctrl_type          cu_ctrl;
   logic signed [CMP_W-1:0]   r0_s, r1_s, rlo_s, rhi_s;
   logic [SWEEP_W-1:0]        sweeps_inc;
   logic                      last_col, last_row;

   assign jac   = (method_ff != METH_GS) && (method_ff != METH_SOR);
   assign omega = (relax_ff > OMEGA_MAX) ? OMEGA_MAX : relax_ff;

   assign req_fire = req_valid && req_ready;
   assign last_col = (i_ff == IDX_MAX);
   assign last_row = (j_ff == ROW_LAST_INT);
   assign sweeps_inc = sweeps_ff + SWEEP_W'(1);

   // cell addressing; the column index i_ff also serves read and rectangle marking
   assign p_addr    = CELL_AW'(rowbase_ff + CELL_AW'(i_ff));
   assign left_idx  = (i_ff == '0) ? IDX_MAX : IDX_W'(i_ff - IDX_W'(1));
   assign right_idx = last_col ? '0 : IDX_W'(i_ff + IDX_W'(1));
   assign bnd_addr  = top_ff ? CELL_AW'(CELL_AW'(TOP_BASE) + CELL_AW'(i_ff))
                             : CELL_AW'(i_ff);

   // row clamp for read and rectangle
   always_comb begin
      r0_s  = CMP_W'(req_row_first);
      r1_s  = CMP_W'(req_row_last);
      rlo_s = (r0_s < 0) ? '0 : r0_s;
      rhi_s = (r1_s > CMP_W'(GRID_N)) ? CMP_W'(GRID_N) : r1_s;
   end

   // bank select for the field memory
   assign fld_raddr = FA_W'(fld_rcell) + (bank_ff ? FA_W'(CELLS) : FA_W'(0));
   assign fld_waddr = FA_W'(fld_wcell) + (fld_wbank ? FA_W'(CELLS) : FA_W'(0));

   // ---------------- memories and cell unit ----------------
   lgrs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (FDEPTH)
   ) u_field (
      .clock   (clock),
      .wr_en   (fld_we),
      .wr_addr (fld_waddr),
      .wr_data (fld_wdata),
      .rd_addr (fld_raddr),
      .rd_data (fld_rdata)
   );

   lgrs_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_obstacle (
      .clock   (clock),
      .wr_en   (obs_we),
      .wr_addr (obs_waddr),
      .wr_data (obs_wdata),
      .rd_addr (obs_raddr),
      .rd_data (obs_rdata)
   );

   lgrs_cell u_cell (
      .clock     (clock),
      .ctrl      (cu_ctrl),
      .rd_value  (fld_rdata),
      .obs       (obs_rdata),
      .omega     (omega),
      .new_value (cu_new),
      .change    (cu_change)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (lgrs_action_type'(req_action))
                  ACT_ADD, ACT_READ: state_in = ST_WRAP;
                  ACT_SOLVE:         state_in = ST_SOLVE;
                  default:           state_in = ST_RESP;
               endcase
            end
         end
         ST_WRAP: begin
            if (wc_ff >= 0 && wc_ff < WR_W'(GRID_N)) begin
               if (act_ff == ACT_READ) begin
                  state_in = ST_RD_ISSUE;
               end else if (empty_ff) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_RECT;
               end
            end
         end
         ST_RECT: begin
            if (ccnt_ff == c1_ff && j_ff == rhi_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_WAIT;
         ST_RD_WAIT:  state_in = ST_RESP;
         ST_SOLVE: begin
            state_in = (maxsw_ff == '0) ? ST_RESP : ST_CELL;
         end
         ST_CELL: begin
            if (phase_ff == PH_WRITE && last_col && last_row) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            if (phase_ff != '0 && last_col && top_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (big_ff < VAL_W'(tol_ff) || sweeps_inc == maxsw_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_CELL;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // ---------------- outputs (memory ports, unit control, handshake) ----------------
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      fld_we    = 1'b0;
      fld_wcell = p_addr;
      fld_wbank = bank_ff;
      fld_wdata = '0;
      fld_rcell = p_addr;
      obs_we    = 1'b0;
      obs_waddr = p_addr;
      obs_wdata = 1'b0;
      obs_raddr = p_addr;
      cu_ctrl   = '0;
      case (state_ff)
         ST_INIT: begin
            fld_we    = 1'b1;
            fld_wcell = clr_ff;
            fld_wbank = 1'b0;
            fld_wdata = (clr_ff >= CELL_AW'(TOP_BASE)) ? VAL_ONE : '0;
            obs_we    = 1'b1;
            obs_waddr = clr_ff;
         end
         ST_IDLE: req_ready = 1'b1;
         ST_RECT: begin
            obs_we    = 1'b1;
            obs_wdata = 1'b1;
         end
         ST_CELL: begin
            case (phase_ff)
               PH_LEFT:  fld_rcell = CELL_AW'(rowbase_ff + CELL_AW'(left_idx));
               PH_RIGHT: fld_rcell = CELL_AW'(rowbase_ff + CELL_AW'(right_idx));
               PH_UP:    fld_rcell = CELL_AW'(p_addr + ROW_STEP);
               PH_DOWN:  fld_rcell = CELL_AW'(p_addr - ROW_STEP);
               default:  fld_rcell = p_addr;
            endcase
            cu_ctrl.load_center = (phase_ff == PH_LEFT);
            cu_ctrl.add_nbr     = (phase_ff inside {[PH_RIGHT:PH_NLAST]});
            cu_ctrl.calc_avg    = (phase_ff == PH_AVG);
            cu_ctrl.calc_diff   = (phase_ff == PH_DIFF);
            cu_ctrl.calc_prod   = (phase_ff == PH_PROD);
            cu_ctrl.sor         = (method_ff == METH_SOR);
            if (phase_ff == PH_WRITE) begin
               fld_we    = 1'b1;
               fld_wbank = jac ? ~bank_ff : bank_ff;
               fld_wdata = cu_new;
            end
         end
         ST_BOUND: begin
            obs_raddr = bnd_addr;
            if (phase_ff != '0) begin
               // obstacles win over the fixed boundary value
               fld_we    = 1'b1;
               fld_wcell = bnd_addr;
               fld_wbank = jac ? ~bank_ff : bank_ff;
               fld_wdata = (obs_rdata || !top_ff) ? '0 : VAL_ONE;
            end
         end
         ST_RESP: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      act_in     = act_ff;
      c0_in      = c0_ff;
      c1_in      = c1_ff;
      ccnt_in    = ccnt_ff;
      rlo_in     = rlo_ff;
      rhi_in     = rhi_ff;
      empty_in   = empty_ff;
      wc_in      = wc_ff;
      wc0_in     = wc0_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      rowbase_in = rowbase_ff;
      clr_in     = clr_ff;
      phase_in   = phase_ff;
      top_in     = top_ff;
      bank_in    = bank_ff;
      big_in     = big_ff;
      sweeps_in  = sweeps_ff;
      conv_in    = conv_ff;
      cell_in    = cell_ff;
      case (state_ff)
         ST_INIT: clr_in = CELL_AW'(clr_ff + CELL_AW'(1));
         ST_IDLE: begin
            if (req_fire) begin
               act_in    = lgrs_action_type'(req_action);
               c0_in     = req_col_first;
               c1_in     = req_col_last;
               wc_in     = WR_W'(req_col_first);
               rlo_in    = (rlo_s > CMP_W'(GRID_N)) ? ROW_W'(GRID_N) : ROW_W'(rlo_s);
               rhi_in    = ROW_W'(rhi_s);
               empty_in  = (req_col_first > req_col_last) || (rlo_s > rhi_s);
               big_in    = '0;
               sweeps_in = '0;
               conv_in   = 1'b0;
               cell_in   = '0;
            end
         end
         ST_WRAP: begin
            // column modulo width, one add or subtract per cycle
            if (wc_ff < 0) begin
               wc_in = WR_W'(wc_ff + WR_W'(GRID_N));
            end else if (wc_ff >= WR_W'(GRID_N)) begin
               wc_in = WR_W'(wc_ff - WR_W'(GRID_N));
            end else begin
               wc0_in     = IDX_W'(wc_ff);
               i_in       = IDX_W'(wc_ff);
               j_in       = rlo_ff;
               ccnt_in    = c0_ff;
               rowbase_in = CELL_AW'(rlo_ff * GRID_N);
            end
         end
         ST_RECT: begin
            if (ccnt_ff == c1_ff) begin
               ccnt_in    = c0_ff;
               i_in       = wc0_ff;
               j_in       = ROW_W'(j_ff + ROW_W'(1));
               rowbase_in = CELL_AW'(rowbase_ff + ROW_STEP);
            end else begin
               ccnt_in = COORD_W'(ccnt_ff + COORD_W'(1));
               i_in    = right_idx;
            end
         end
         ST_RD_WAIT: cell_in = fld_rdata;
         ST_SOLVE: begin
            big_in     = '0;
            i_in       = '0;
            j_in       = ROW_W'(1);
            rowbase_in = ROW_STEP;
            phase_in   = '0;
         end
         ST_CELL: begin
            if (phase_ff == PH_WRITE) begin
               phase_in = '0;
               if (cu_change > big_ff) begin
                  big_in = cu_change;
               end
               if (last_col) begin
                  i_in = '0;
                  if (last_row) begin
                     top_in = 1'b0;
                  end else begin
                     j_in       = ROW_W'(j_ff + ROW_W'(1));
                     rowbase_in = CELL_AW'(rowbase_ff + ROW_STEP);
                  end
               end else begin
                  i_in = right_idx;
               end
            end else begin
               phase_in = PH_W'(phase_ff + PH_W'(1));
            end
         end
         ST_BOUND: begin
            if (phase_ff == '0) begin
               phase_in = PH_W'(1);
            end else begin
               phase_in = '0;
               if (last_col) begin
                  i_in   = '0;
                  top_in = 1'b1;
               end else begin
                  i_in = right_idx;
               end
            end
         end
         ST_CHECK: begin
            sweeps_in = sweeps_inc;
            if (jac) begin
               bank_in = ~bank_ff;
            end
            if (big_ff < VAL_W'(tol_ff)) begin
               conv_in = 1'b1;
            end else if (sweeps_inc != maxsw_ff) begin
               big_in     = '0;
               i_in       = '0;
               j_in       = ROW_W'(1);
               rowbase_in = ROW_STEP;
               phase_in   = '0;
            end
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         clr_ff    <= '0;
         bank_ff   <= 1'b0;
         method_ff <= METHOD_RST;
         relax_ff  <= RELAX_RST;
         tol_ff    <= TOL_RST;
         maxsw_ff  <= MAXSW_RST;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         bank_ff  <= bank_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_METHOD: method_ff <= csr_wdata[METHOD_W-1:0];
               CSR_RELAX:  relax_ff  <= csr_wdata;
               CSR_TOL:    tol_ff    <= csr_wdata;
               CSR_MAXSW:  maxsw_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_in_reg: begin
         act_ff     <= act_in;
         c0_ff      <= c0_in;
         c1_ff      <= c1_in;
         ccnt_ff    <= ccnt_in;
         rlo_ff     <= rlo_in;
         rhi_ff     <= rhi_in;
         empty_ff   <= empty_in;
         wc_ff      <= wc_in;
         wc0_ff     <= wc0_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         rowbase_ff <= rowbase_in;
         phase_ff   <= phase_in;
         top_ff     <= top_in;
         big_ff     <= big_in;
         sweeps_ff  <= sweeps_in;
         conv_ff    <= conv_in;
         cell_ff    <= cell_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cell_ff   <= cell_ff;
         rsp_sweeps_ff <= sweeps_ff;
         rsp_change_ff <= (big_ff > CHG_SAT) ? CHG_W'(CHG_SAT) : CHG_W'(big_ff);
         rsp_conv_ff   <= conv_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_value   = rsp_cell_ff;
   assign rsp_sweeps_done  = rsp_sweeps_ff;
   assign rsp_final_change = rsp_change_ff;
   assign rsp_converged    = rsp_conv_ff;

   // ---------------- assertions ----------------
   a_bound_follows_cells: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_BOUND) |-> $past(state_ff) == ST_CELL)
      else $error("boundary pass entered without interior pass");

   a_sweeps_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && act_ff == ACT_SOLVE) |-> sweeps_ff <= maxsw_ff)
      else $error("sweep count beyond limit");

   a_conv_below_tol: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && conv_ff) |-> big_ff < VAL_W'(tol_ff))
      else $error("converged flag with change at or above tolerance");

endmodule
